@@ hdl/ocx_pkg.sv @@
// Package for the order crossover block: shared widths, controller state type,
// and the command/status structs that join the controller and the datapath.
// Depends on nothing.
package ocx_pkg;

    localparam int CITY_W = 6;

    typedef enum logic [2:0] {
        S_LOAD,
        S_MARK_RD,
        S_MARK_SET,
        S_POS,
        S_SEL
    } t_state;

    typedef struct packed {
        logic accept;    // item taken this cycle
        logic mark_set;  // record segment city from mother read data
        logic sel;       // evaluate child position from read data
        logic active;    // crossover in progress
    } t_cmd;

    typedef struct packed {
        logic seg_done;  // marking pointer sits on the upper cut
        logic emit;      // current selection produces a child city
        logic pos_last;  // current child position is the final one
    } t_stat;

endpackage

@@ hdl/ocx_ctrl.sv @@
// Controller state machine for the order crossover block.
// Depends on ocx_pkg; drives commands to ocx_datapath and reads its status.
module ocx_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            i_last_element,
    input  ocx_pkg::t_stat  i_stat,
    output ocx_pkg::t_cmd   o_cmd,
    output logic            busy
);

    ocx_pkg::t_state r_state;
    ocx_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ocx_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ocx_pkg::S_LOAD: begin
                if (start && i_last_element) begin
                    n_state = ocx_pkg::S_MARK_RD;
                end
            end
            ocx_pkg::S_MARK_RD: begin
                n_state = ocx_pkg::S_MARK_SET;
            end
            ocx_pkg::S_MARK_SET: begin
                n_state = i_stat.seg_done ? ocx_pkg::S_POS : ocx_pkg::S_MARK_RD;
            end
            ocx_pkg::S_POS: begin
                n_state = ocx_pkg::S_SEL;
            end
            ocx_pkg::S_SEL: begin
                n_state = (i_stat.emit && i_stat.pos_last) ? ocx_pkg::S_LOAD
                                                           : ocx_pkg::S_POS;
            end
            default: begin
                n_state = ocx_pkg::S_LOAD;
            end
        endcase
    end

    always_comb begin
        busy            = (r_state != ocx_pkg::S_LOAD);
        o_cmd.accept    = start && (r_state == ocx_pkg::S_LOAD);
        o_cmd.mark_set  = (r_state == ocx_pkg::S_MARK_SET);
        o_cmd.sel       = (r_state == ocx_pkg::S_SEL);
        o_cmd.active    = (r_state != ocx_pkg::S_LOAD);
    end

endmodule

@@ hdl/ocx_datapath.sv @@
// Datapath for the order crossover block: parent stores, segment marks,
// cut registers, position and father pointers, and the result register.
// Depends on ocx_pkg; commanded by ocx_ctrl.
module ocx_datapath #(
    parameter int MAX_CITIES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ocx_pkg::t_cmd               i_cmd,
    output ocx_pkg::t_stat              o_stat,
    input  logic [ocx_pkg::CITY_W-1:0]  i_father_city,
    input  logic [ocx_pkg::CITY_W-1:0]  i_mother_city,
    input  logic [ocx_pkg::CITY_W-1:0]  i_cut_first,
    input  logic [ocx_pkg::CITY_W-1:0]  i_cut_last,
    input  logic                        i_last_element,
    output logic                        o_strobe,
    output logic [ocx_pkg::CITY_W-1:0]  o_child_city,
    output logic [ocx_pkg::CITY_W-1:0]  o_child_position,
    output logic                        o_last_city
);

    localparam int CW   = ocx_pkg::CITY_W;
    localparam int AW   = $clog2(MAX_CITIES);
    localparam int CNTW = $clog2(MAX_CITIES + 1);
    localparam int CMPW = CW + 1;
    localparam int SPAN = 2 ** CW;

    logic [CW-1:0]   r_fmem [MAX_CITIES];
    logic [CW-1:0]   r_mmem [MAX_CITIES];
    logic [CW-1:0]   r_fq;
    logic [CW-1:0]   r_mq;
    logic [SPAN-1:0] r_mark;
    logic [CNTW-1:0] r_cnt;
    logic [CNTW-1:0] r_len;
    logic [CNTW-1:0] r_k;
    logic [AW-1:0]   r_idx;
    logic [AW-1:0]   r_lo;
    logic [AW-1:0]   r_hi;

    logic            w_full;
    logic [CNTW-1:0] w_len;
    logic [AW-1:0]   w_c1;
    logic [AW-1:0]   w_c2;
    logic            w_in_seg;
    logic            w_f_done;
    logic            w_skip;

    assign w_full = (r_cnt == CNTW'(MAX_CITIES));
    assign w_len  = w_full ? r_cnt : r_cnt + CNTW'(1);

    // saturate each cut to len - 1
    assign w_c1 = (CMPW'(i_cut_first) >= CMPW'(w_len)) ? AW'(w_len - CNTW'(1))
                                                       : AW'(i_cut_first);
    assign w_c2 = (CMPW'(i_cut_last) >= CMPW'(w_len)) ? AW'(w_len - CNTW'(1))
                                                      : AW'(i_cut_last);

    assign w_in_seg = (r_idx >= r_lo) && (r_idx <= r_hi);
    assign w_f_done = (r_k >= r_len);
    assign w_skip   = !w_in_seg && !w_f_done && r_mark[r_fq];

    assign o_stat.seg_done = (r_idx == r_hi);
    assign o_stat.emit     = !w_skip;
    assign o_stat.pos_last = ((CNTW'(r_idx) + CNTW'(1)) == r_len);

    // parent stores: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !w_full) begin
            r_fmem[r_cnt[AW-1:0]] <= i_father_city;
            r_mmem[r_cnt[AW-1:0]] <= i_mother_city;
        end
        r_fq <= r_fmem[r_k[AW-1:0]];
        r_mq <= r_mmem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_mark   <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_cmd.sel && !w_skip;
            if (i_cmd.accept) begin
                if (i_last_element) begin
                    r_cnt  <= '0;
                    r_mark <= '0;
                end else if (!w_full) begin
                    r_cnt <= r_cnt + CNTW'(1);
                end
            end
            if (i_cmd.mark_set) begin
                r_mark[r_mq] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_last_element) begin
            r_len <= w_len;
            r_k   <= '0;
            r_lo  <= (w_c1 > w_c2) ? w_c2 : w_c1;
            r_hi  <= (w_c1 > w_c2) ? w_c1 : w_c2;
            r_idx <= (w_c1 > w_c2) ? w_c2 : w_c1;
        end
        if (i_cmd.mark_set) begin
            r_idx <= (r_idx == r_hi) ? '0 : r_idx + AW'(1);
        end
        if (i_cmd.sel) begin
            if (!w_in_seg && !w_f_done) begin
                r_k <= r_k + CNTW'(1);
            end
            if (!w_skip) begin
                r_idx <= r_idx + AW'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.sel) begin
            o_child_city     <= w_in_seg ? r_mq : (w_f_done ? '0 : r_fq);
            o_child_position <= CW'(r_idx);
            o_last_city      <= o_stat.pos_last;
        end
    end

    a_cut_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.active |-> r_lo <= r_hi)
        else $error("lower cut above upper cut");

    a_cut_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.active |-> CNTW'(r_hi) < r_len)
        else $error("upper cut beyond list length");

    a_father_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.active |-> r_k <= r_len)
        else $error("father pointer ran past list length");

endmodule

@@ hdl/order_crossover_permutation.sv @@
// Top level of the order crossover block: ties the controller to the datapath.
// Depends on ocx_pkg, ocx_ctrl and ocx_datapath.
//
// Loading takes one cycle per item while busy is low; the item with
// i_last_element set closes the list and carries the cut points. The block
// then holds busy high while it marks the mother's segment (S_MARK_RD then
// S_MARK_SET per segment position) and builds the child (S_POS then S_SEL per
// child position, plus another S_POS/S_SEL pass per father city skipped
// because it lies in the segment). The states pair up because each parent
// store has one registered read port: a lookup needs an address state and a
// data state. Each child city appears on the outputs for a single cycle with
// o_strobe high and the receiver cannot stall it; o_last_city marks the final
// one; busy is low in that cycle, so the next list can start loading then.
module order_crossover_permutation #(
    parameter int MAX_CITIES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ocx_pkg::CITY_W-1:0]  i_father_city,
    input  logic [ocx_pkg::CITY_W-1:0]  i_mother_city,
    input  logic [ocx_pkg::CITY_W-1:0]  i_cut_first,
    input  logic [ocx_pkg::CITY_W-1:0]  i_cut_last,
    input  logic                        i_last_element,
    output logic                        o_strobe,
    output logic [ocx_pkg::CITY_W-1:0]  o_child_city,
    output logic [ocx_pkg::CITY_W-1:0]  o_child_position,
    output logic                        o_last_city
);

    ocx_pkg::t_cmd  w_cmd;
    ocx_pkg::t_stat w_stat;

    ocx_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_last_element (i_last_element),
        .i_stat         (w_stat),
        .o_cmd          (w_cmd),
        .busy           (busy)
    );

    ocx_datapath #(
        .MAX_CITIES (MAX_CITIES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_father_city    (i_father_city),
        .i_mother_city    (i_mother_city),
        .i_cut_first      (i_cut_first),
        .i_cut_last       (i_cut_last),
        .i_last_element   (i_last_element),
        .o_strobe         (o_strobe),
        .o_child_city     (o_child_city),
        .o_child_position (o_child_position),
        .o_last_city      (o_last_city)
    );

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result emitted outside a crossover");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last_city |-> !busy)
        else $error("still busy after final child city");

endmodule

@@ verif/order_crossover_checker.sv @@
`timescale 1ns / 1ps
// Checker for the order crossover block: mirrors parent loading, predicts every
// child city and compares the strobed results in order. Depends on ocx_pkg.
module order_crossover_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [ocx_pkg::CITY_W-1:0]  i_father_city,
    input  logic [ocx_pkg::CITY_W-1:0]  i_mother_city,
    input  logic [ocx_pkg::CITY_W-1:0]  i_cut_first,
    input  logic [ocx_pkg::CITY_W-1:0]  i_cut_last,
    input  logic                        i_last_element,
    input  logic                        i_strobe,
    input  logic [ocx_pkg::CITY_W-1:0]  i_child_city,
    input  logic [ocx_pkg::CITY_W-1:0]  i_child_position,
    input  logic                        i_last_city,
    output int                          o_errors,
    output int                          o_pending
);
    localparam int CITY_W = ocx_pkg::CITY_W;
    localparam int STORE_DEPTH = 64;

    typedef struct packed {
        logic [CITY_W-1:0] city;
        logic [CITY_W-1:0] position;
        logic              final_city;
    } t_child;

    logic [CITY_W-1:0] father_store [STORE_DEPTH];
    logic [CITY_W-1:0] mother_store [STORE_DEPTH];
    int unsigned       loaded_count;
    t_child            child_queue [$];
    int                error_count;

    task automatic flag_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Build the child tour from the loaded parents and queue it.
    task automatic predict_child(input int unsigned cut_a, input int unsigned cut_b);
        int unsigned       len;
        int unsigned       lo;
        int unsigned       hi;
        int unsigned       swap;
        int unsigned       pos;
        int unsigned       next_father;
        logic [63:0]       in_segment;
        t_child            child;
        len = loaded_count;
        lo = (cut_a >= len) ? len - 1 : cut_a;
        hi = (cut_b >= len) ? len - 1 : cut_b;
        if (lo > hi) begin
            swap = lo;
            lo = hi;
            hi = swap;
        end
        in_segment = '0;
        for (pos = lo; pos <= hi; pos++) begin
            in_segment[mother_store[pos]] = 1'b1;
        end
        next_father = 0;
        for (pos = 0; pos < len; pos++) begin
            if (pos >= lo && pos <= hi) begin
                child.city = mother_store[pos];
            end else begin
                while (next_father < len && in_segment[father_store[next_father]]) begin
                    next_father++;
                end
                if (next_father < len) begin
                    child.city = father_store[next_father];
                    next_father++;
                end else begin
                    child.city = '0;
                end
            end
            child.position = pos[CITY_W-1:0];
            child.final_city = (pos + 1 == len);
            child_queue.insert(child_queue.size(), child);
        end
    endtask

    always @(posedge i_clk) begin
        t_child want;
        if (!i_rst_n) begin
            loaded_count = 0;
            child_queue.delete();
        end else begin
            if (i_start && !i_busy) begin
                if (loaded_count < STORE_DEPTH) begin
                    father_store[loaded_count] = i_father_city;
                    mother_store[loaded_count] = i_mother_city;
                    loaded_count++;
                end
                if (i_last_element) begin
                    predict_child(int'(i_cut_first), int'(i_cut_last));
                    loaded_count = 0;
                end
            end
            if ($isunknown(i_strobe)) begin
                flag_mismatch("result strobe is unknown");
            end else if (i_strobe) begin
                if (child_queue.size() == 0) begin
                    flag_mismatch($sformatf("unexpected child city %0d at position %0d",
                                            i_child_city, i_child_position));
                end else begin
                    want = child_queue.pop_front();
                    if (i_child_city !== want.city)
                        flag_mismatch($sformatf("position %0d: city %0d, expected %0d",
                                                want.position, i_child_city, want.city));
                    if (i_child_position !== want.position)
                        flag_mismatch($sformatf("position field %0d, expected %0d",
                                                i_child_position, want.position));
                    if (i_last_city !== want.final_city)
                        flag_mismatch($sformatf("position %0d: last flag %b, expected %b",
                                                want.position, i_last_city, want.final_city));
                end
            end
        end
        o_errors <= error_count;
        o_pending <= child_queue.size();
    end

endmodule

@@ verif/order_crossover_permutation_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the order crossover block: drives parent lists with cut
// points in bursts and gives the verdict. Depends on ocx_pkg and the checker.
module order_crossover_permutation_test;
    localparam int CITY_W = ocx_pkg::CITY_W;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [CITY_W-1:0] i_father_city = '0;
    logic [CITY_W-1:0] i_mother_city = '0;
    logic [CITY_W-1:0] i_cut_first = '0;
    logic [CITY_W-1:0] i_cut_last = '0;
    logic              i_last_element = 1'b0;
    logic              o_strobe;
    logic [CITY_W-1:0] o_child_city;
    logic [CITY_W-1:0] o_child_position;
    logic              o_last_city;
    int                errors;
    int                pending;

    int                burst_left = 4;
    int                items_sent = 0;
    logic [CITY_W-1:0] father_list [70];
    logic [CITY_W-1:0] mother_list [70];
    int                city_pool [64];

    order_crossover_permutation uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_father_city    (i_father_city),
        .i_mother_city    (i_mother_city),
        .i_cut_first      (i_cut_first),
        .i_cut_last       (i_cut_last),
        .i_last_element   (i_last_element),
        .o_strobe         (o_strobe),
        .o_child_city     (o_child_city),
        .o_child_position (o_child_position),
        .o_last_city      (o_last_city)
    );

    order_crossover_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_father_city    (i_father_city),
        .i_mother_city    (i_mother_city),
        .i_cut_first      (i_cut_first),
        .i_cut_last       (i_cut_last),
        .i_last_element   (i_last_element),
        .i_strobe         (o_strobe),
        .i_child_city     (o_child_city),
        .i_child_position (o_child_position),
        .i_last_city      (o_last_city),
        .o_errors         (errors),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("FAIL order_crossover_permutation");
        $finish;
    end

    // Present one item and hold it until taken; then maybe drop start for a gap.
    task automatic send_city(input logic [CITY_W-1:0] father, input logic [CITY_W-1:0] mother,
                             input logic [CITY_W-1:0] cut_a, input logic [CITY_W-1:0] cut_b,
                             input logic last_flag);
        i_father_city <= father;
        i_mother_city <= mother;
        i_cut_first <= cut_a;
        i_cut_last <= cut_b;
        i_last_element <= last_flag;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                       : $urandom_range(1, 12);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic shuffle_pool(input int count);
        int idx;
        int pick;
        int held;
        for (idx = count - 1; idx > 0; idx--) begin
            pick = $urandom_range(0, idx);
            held = city_pool[idx];
            city_pool[idx] = city_pool[pick];
            city_pool[pick] = held;
        end
    endtask

    // Send one parent list; positions past the store depth carry random cities.
    task automatic send_list(input int len, input bit as_perm, input int cut_a, input int cut_b);
        int stored;
        int idx;
        int span;
        stored = (len > 64) ? 64 : len;
        span = ($urandom_range(0, 1) != 0) ? 63 : len;
        if (as_perm) begin
            for (idx = 0; idx < 64; idx++) city_pool[idx] = idx;
            shuffle_pool(64);
            for (idx = 0; idx < stored; idx++) father_list[idx] = CITY_W'(city_pool[idx]);
            shuffle_pool(stored);
            for (idx = 0; idx < stored; idx++) mother_list[idx] = CITY_W'(city_pool[idx]);
        end else begin
            for (idx = 0; idx < stored; idx++) begin
                father_list[idx] = CITY_W'($urandom_range(0, span));
                mother_list[idx] = CITY_W'($urandom_range(0, span));
            end
        end
        for (idx = stored; idx < len; idx++) begin
            father_list[idx] = CITY_W'($urandom_range(0, 63));
            mother_list[idx] = CITY_W'($urandom_range(0, 63));
        end
        for (idx = 0; idx < len - 1; idx++) begin
            send_city(father_list[idx], mother_list[idx],
                      CITY_W'($urandom_range(0, 63)), CITY_W'($urandom_range(0, 63)), 1'b0);
        end
        send_city(father_list[len - 1], mother_list[len - 1],
                  CITY_W'(cut_a), CITY_W'(cut_b), 1'b1);
    endtask

    function automatic int pick_cut(input int len);
        pick_cut = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 63)
                                               : $urandom_range(0, len - 1);
    endfunction

    initial begin
        int len;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single city, both cuts saturate onto position zero
        send_city(6'd63, 6'd63, 6'd63, 6'd63, 1'b1);
        // ordered cuts inside the list, extreme city values
        send_city(6'd63, 6'd0, 6'd0, 6'd0, 1'b0);
        send_city(6'd0, 6'd42, 6'd0, 6'd0, 1'b0);
        send_city(6'd21, 6'd63, 6'd0, 6'd0, 1'b0);
        send_city(6'd42, 6'd21, 6'd1, 6'd2, 1'b1);
        // reversed cuts spanning the whole list
        send_city(6'd63, 6'd0, 6'd0, 6'd0, 1'b0);
        send_city(6'd0, 6'd42, 6'd0, 6'd0, 1'b0);
        send_city(6'd21, 6'd63, 6'd0, 6'd0, 1'b0);
        send_city(6'd42, 6'd21, 6'd3, 6'd0, 1'b1);
        wait_drained();
        // first cut beyond the list end
        send_city(6'd10, 6'd14, 6'd0, 6'd0, 1'b0);
        send_city(6'd11, 6'd13, 6'd0, 6'd0, 1'b0);
        send_city(6'd12, 6'd12, 6'd0, 6'd0, 1'b0);
        send_city(6'd13, 6'd11, 6'd0, 6'd0, 1'b0);
        send_city(6'd14, 6'd10, 6'd40, 6'd2, 1'b1);
        // father runs out of cities outside the segment
        send_city(6'd5, 6'd5, 6'd0, 6'd0, 1'b0);
        send_city(6'd5, 6'd1, 6'd0, 6'd0, 1'b0);
        send_city(6'd5, 6'd2, 6'd0, 6'd0, 1'b0);
        send_city(6'd7, 6'd3, 6'd0, 6'd0, 1'b1);
        // duplicated father city used twice, spare father city dropped
        send_city(6'd1, 6'd9, 6'd0, 6'd0, 1'b0);
        send_city(6'd1, 6'd9, 6'd0, 6'd0, 1'b0);
        send_city(6'd2, 6'd9, 6'd0, 6'd0, 1'b0);
        send_city(6'd3, 6'd9, 6'd3, 6'd3, 1'b1);

        // full store, then a list that overflows it
        send_list(64, 1'b1, pick_cut(64), pick_cut(64));
        len = 64 + $urandom_range(1, 4);
        send_list(len, 1'b1, $urandom_range(0, 63), $urandom_range(0, 63));
        wait_drained();

        while (items_sent < 215) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                              : $urandom_range(1, 12);
            send_list(len, $urandom_range(0, 4) != 0, pick_cut(len), pick_cut(len));
            if ($urandom_range(0, 7) == 0) wait_drained();
        end

        wait_drained();
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS order_crossover_permutation");
        end else begin
            $display("FAIL order_crossover_permutation");
        end
        $finish;
    end

endmodule
